FILE: hw/rtl/tcw_pkg.sv
package tcw_pkg;

    // default screen geometry
    localparam int SCREEN_ROWS_DEF = 25;
    localparam int SCREEN_COLS_DEF = 80;

    // field widths of the stream payloads
    localparam int CHAR_W    = 8;
    localparam int INDEX_W   = 11;
    localparam int VALUE_W   = 16;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int ATTR_W    = 8;

    localparam int S_TDATA_W = 24;  // char_code, cell_index, pad
    localparam int M_TDATA_W = 32;  // cell_value, cursor_row, cursor_col, pad

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
    localparam int                TAB_STEP   = 8;

    localparam int QUEUE_DEPTH = 2;

    // control characters
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;

    // request kind on tuser
    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [2:0] {
        OP_GLYPH     = 3'd0,
        OP_NEWLINE   = 3'd1,
        OP_RETURN    = 3'd2,
        OP_BACKSPACE = 3'd3,
        OP_TAB       = 3'd4,
        OP_READ      = 3'd5
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CHAR_W-1:0]  char_code;
        logic [INDEX_W-1:0] cell_index;
    } item_t;

endpackage

FILE: hw/rtl/tcw_front.sv
module tcw_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tcw_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]                    s_tuser,
    output logic                          item_valid,
    input  logic                          item_ready,
    output tcw_pkg::item_t                item
);

    logic           valid_reg;
    logic           valid_next;
    tcw_pkg::item_t item_reg;
    tcw_pkg::item_t item_next;
    logic           take;

    assign s_tready = !valid_reg || item_ready;
    assign take     = s_tvalid && s_tready;

    // decode the request into an operation for the back end
    always_comb
    begin
        item_next.char_code  = s_tdata[7:0];
        item_next.cell_index = s_tdata[18:8];
        if (s_tuser[0] == tcw_pkg::KIND_READ)
        begin
            item_next.op = tcw_pkg::OP_READ;
        end
        else
        begin
            unique case (s_tdata[7:0])
                tcw_pkg::CH_NEWLINE:   item_next.op = tcw_pkg::OP_NEWLINE;
                tcw_pkg::CH_RETURN:    item_next.op = tcw_pkg::OP_RETURN;
                tcw_pkg::CH_BACKSPACE: item_next.op = tcw_pkg::OP_BACKSPACE;
                tcw_pkg::CH_TAB:       item_next.op = tcw_pkg::OP_TAB;
                default:               item_next.op = tcw_pkg::OP_GLYPH;
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: hw/rtl/tcw_queue.sv
module tcw_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tcw_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output tcw_pkg::item_t out_item
);

    localparam int PW = (tcw_pkg::QUEUE_DEPTH > 1) ? $clog2(tcw_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(tcw_pkg::QUEUE_DEPTH + 1);

    tcw_pkg::item_t slots [tcw_pkg::QUEUE_DEPTH];

    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CNT_W'(tcw_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: hw/rtl/tcw_back.sv
module tcw_back #(
    parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF,
    parameter int SCREEN_COLS = tcw_pkg::SCREEN_COLS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tcw_pkg::ATTR_W-1:0]      cfg_wr_data,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  tcw_pkg::item_t                  q_item,
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic [tcw_pkg::VALUE_W-1:0]     res_value,
    output logic [tcw_pkg::ROW_OUT_W-1:0]   res_row,
    output logic [tcw_pkg::COL_OUT_W-1:0]   res_col
);

    localparam int CELLS  = SCREEN_ROWS * SCREEN_COLS;
    localparam int AW     = $clog2(CELLS);
    localparam int RW     = $clog2(SCREEN_ROWS);
    localparam int CW     = $clog2(SCREEN_COLS);
    localparam int MOVE_N = (SCREEN_ROWS - 1) * SCREEN_COLS;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_MOVE  = 5'b01000,
        ST_BLANK = 5'b10000
    } state_t;

    function automatic logic [tcw_pkg::ROW_OUT_W-1:0] row_out(input logic [RW-1:0] r);
        logic [31:0] w;
        w = 32'(r);
        return w[tcw_pkg::ROW_OUT_W-1:0];
    endfunction

    function automatic logic [tcw_pkg::COL_OUT_W-1:0] col_out(input logic [CW-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[tcw_pkg::COL_OUT_W-1:0];
    endfunction

    logic [tcw_pkg::VALUE_W-1:0] mem [CELLS];

    state_t                       state_reg, state_next;
    logic [RW-1:0]                row_reg, row_next;
    logic [CW-1:0]                col_reg, col_next;
    logic [AW-1:0]                cnt_reg, cnt_next;
    logic [tcw_pkg::ATTR_W-1:0]   attr_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [tcw_pkg::VALUE_W-1:0]  out_value_reg, out_value_next;
    logic [tcw_pkg::ROW_OUT_W-1:0] out_row_reg, out_row_next;
    logic [tcw_pkg::COL_OUT_W-1:0] out_col_reg, out_col_next;
    logic                         load_out;

    logic                         mem_we;
    logic [AW-1:0]                mem_wa;
    logic [tcw_pkg::VALUE_W-1:0]  mem_wd;
    logic [AW-1:0]                mem_ra;
    logic [tcw_pkg::VALUE_W-1:0]  rd_data_reg;

    logic                         out_free;
    logic [CW:0]                  col_inc;
    logic [CW:0]                  tab_col;
    logic                         row_last;
    logic [AW-1:0]                glyph_addr;
    logic                         wrap;

    assign out_free   = !out_valid_reg || res_ready;
    assign q_ready    = (state_reg == ST_IDLE) && out_free;
    assign col_inc    = {1'b0, col_reg} + 1'b1;
    assign tab_col    = ({1'b0, col_reg} + (CW+1)'(tcw_pkg::TAB_STEP))
                        & ~(CW+1)'(tcw_pkg::TAB_STEP - 1);
    assign row_last   = row_reg == RW'(SCREEN_ROWS - 1);
    assign glyph_addr = AW'(32'(row_reg) * 32'(SCREEN_COLS) + 32'(col_reg));

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        cnt_next       = cnt_reg;
        mem_we         = 1'b0;
        mem_wa         = '0;
        mem_wd         = '0;
        mem_ra         = '0;
        load_out       = 1'b0;
        out_value_next = '0;
        out_row_next   = row_out(row_reg);
        out_col_next   = col_out(col_reg);
        wrap           = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = cnt_reg;
                if (cnt_reg == AW'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    case (q_item.op)
                        tcw_pkg::OP_GLYPH:
                        begin
                            mem_we = 1'b1;
                            mem_wa = glyph_addr;
                            mem_wd = {attr_reg, q_item.char_code};
                            if (col_inc >= (CW+1)'(SCREEN_COLS))
                            begin
                                col_next = '0;
                                wrap     = 1'b1;
                            end
                            else
                            begin
                                col_next = col_inc[CW-1:0];
                            end
                        end
                        tcw_pkg::OP_NEWLINE:
                        begin
                            col_next = '0;
                            wrap     = 1'b1;
                        end
                        tcw_pkg::OP_RETURN:
                        begin
                            col_next = '0;
                        end
                        tcw_pkg::OP_BACKSPACE:
                        begin
                            if (col_reg != '0)
                            begin
                                col_next = col_reg - 1'b1;
                            end
                            else if (row_reg != '0)
                            begin
                                row_next = row_reg - 1'b1;
                            end
                        end
                        tcw_pkg::OP_TAB:
                        begin
                            if (tab_col >= (CW+1)'(SCREEN_COLS))
                            begin
                                col_next = '0;
                                wrap     = 1'b1;
                            end
                            else
                            begin
                                col_next = tab_col[CW-1:0];
                            end
                        end
                        tcw_pkg::OP_READ:
                        begin
                            if (32'(q_item.cell_index) < 32'(CELLS))
                            begin
                                mem_ra     = AW'(q_item.cell_index);
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    // cursor past the last row: scroll before answering
                    if (wrap && row_last)
                    begin
                        cnt_next   = '0;
                        state_next = ST_MOVE;
                    end
                    else
                    begin
                        if (wrap)
                        begin
                            row_next = row_reg + 1'b1;
                        end
                        if (state_next == ST_IDLE)
                        begin
                            load_out     = 1'b1;
                            out_row_next = row_out(row_next);
                            out_col_next = col_out(col_next);
                        end
                    end
                end
            end

            ST_READ:
            begin
                load_out       = 1'b1;
                out_value_next = rd_data_reg;
                state_next     = ST_IDLE;
            end

            ST_MOVE:
            begin
                // read one row ahead, write the cell fetched last cycle
                if (cnt_reg != AW'(MOVE_N))
                begin
                    mem_ra = AW'(32'(cnt_reg) + 32'(SCREEN_COLS));
                end
                if (cnt_reg != '0)
                begin
                    mem_we = 1'b1;
                    mem_wa = cnt_reg - 1'b1;
                    mem_wd = rd_data_reg;
                end
                if (cnt_reg == AW'(MOVE_N))
                begin
                    state_next = ST_BLANK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_BLANK:
            begin
                mem_we = 1'b1;
                mem_wa = cnt_reg;
                if (cnt_reg == AW'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            row_reg       <= '0;
            col_reg       <= '0;
            cnt_reg       <= '0;
            attr_reg      <= tcw_pkg::ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                attr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_value_reg <= out_value_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
        end
    end

    // screen store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    assign res_valid = out_valid_reg;
    assign res_value = out_value_reg;
    assign res_row   = out_row_reg;
    assign res_col   = out_col_reg;

endmodule

FILE: hw/rtl/text_console_writer_top.sv
// Text console writer: keeps a SCREEN_ROWS x SCREEN_COLS screen of 16-bit cells
// (attribute in bits 15..8, glyph in 7..0) and a cursor. Each request on the
// slave stream either puts one byte at the cursor (tuser = 0) or reads one cell
// (tuser = 1); every request returns exactly one response carrying the read
// cell (zero for puts) and the cursor after the request. Newline, carriage
// return, backspace and tab move the cursor; any other byte is stored with the
// attribute register and advances the cursor. After reset the screen store is
// swept to zero, one cell per cycle, before the first request is carried out;
// up to three requests are accepted meanwhile (one in the front register, two
// in the queue). Attribute writes are taken at any time. A put is handled in
// the idle state alone; a read also passes through a read state, since the
// screen memory read is registered. A request that runs the cursor past the
// last row triggers a scroll that copies the screen up through the single
// memory port pair, one cell per cycle, then clears the bottom row. Front end
// and back end are decoupled by a two-entry queue, so requests keep flowing
// in while the back end scrolls until the queue fills.
module text_console_writer_top #(
    parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF,  // 2..32
    parameter int SCREEN_COLS = tcw_pkg::SCREEN_COLS_DEF   // 8..128
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // attribute register
    input  logic                          cfg_wr_en,
    input  logic [tcw_pkg::ATTR_W-1:0]    cfg_wr_data,

    // request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tcw_pkg::S_TDATA_W-1:0] s_tdata,   // char_code[7:0], cell_index[18:8], zero pad
    input  logic [0:0]                    s_tuser,   // kind[0]: 0 put, 1 read

    // response stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tcw_pkg::M_TDATA_W-1:0] m_tdata    // cell_value[15:0], cursor_row[20:16],
                                                     // cursor_col[27:21], zero pad
);

    logic           fe_valid;
    logic           fe_ready;
    tcw_pkg::item_t fe_item;

    logic           q_valid;
    logic           q_ready;
    tcw_pkg::item_t q_item;

    logic [tcw_pkg::VALUE_W-1:0]   res_value;
    logic [tcw_pkg::ROW_OUT_W-1:0] res_row;
    logic [tcw_pkg::COL_OUT_W-1:0] res_col;

    // front end: registers and classifies each request
    tcw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (fe_valid),
        .item_ready (fe_ready),
        .item       (fe_item)
    );

    // short queue so the front keeps accepting while the back end scrolls
    tcw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_item   (fe_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // back end: cursor, screen memory, scroll/clear sweeps, response register
    tcw_back #(
        .SCREEN_ROWS (SCREEN_ROWS),
        .SCREEN_COLS (SCREEN_COLS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_value   (res_value),
        .res_row     (res_row),
        .res_col     (res_col)
    );

    assign m_tdata = {4'b0000, res_col, res_row, res_value};

endmodule

FILE: sim/testbench.sv
// Stream-level check of text_console_writer_top: every request gets one response
// (read cell + cursor) which is compared against a behavioral screen/cursor model.
module testbench;

    localparam int CHAR_W    = tcw_pkg::CHAR_W;
    localparam int INDEX_W   = tcw_pkg::INDEX_W;
    localparam int VALUE_W   = tcw_pkg::VALUE_W;
    localparam int ROW_OUT_W = tcw_pkg::ROW_OUT_W;
    localparam int COL_OUT_W = tcw_pkg::COL_OUT_W;
    localparam int ATTR_W    = tcw_pkg::ATTR_W;

    localparam int ROWS      = tcw_pkg::SCREEN_ROWS_DEF;
    localparam int COLS      = tcw_pkg::SCREEN_COLS_DEF;
    localparam int CELLS     = ROWS * COLS;
    localparam int CIW       = $clog2(CELLS);
    localparam int CLK_HALF  = 6;
    localparam int STALL_LEN = 300;   // long receiver hold-off, in cycles
    localparam int STALL_GAP = 800;   // requests between two hold-offs
    localparam int JITTER_PCT = 33;   // idle cycles per hundred on each side

    // one request as queued for the driver
    typedef struct packed {
        logic               kind;
        logic [CHAR_W-1:0]  char_code;
        logic [INDEX_W-1:0] cell_index;
    } console_req_t;

    // one response as predicted
    typedef struct packed {
        logic [VALUE_W-1:0]   cell_value;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_col;
    } console_reply_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [ATTR_W-1:0]             cfg_wr_data = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [tcw_pkg::S_TDATA_W-1:0] s_tdata = '0;   // char_code[7:0], cell_index[18:8], zero pad
    logic [0:0]                    s_tuser = '0;   // kind[0]: 0 put, 1 read
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [tcw_pkg::M_TDATA_W-1:0] m_tdata;        // cell_value[15:0], cursor_row[20:16],
                                                   // cursor_col[27:21], zero pad

    text_console_writer_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // ------------------------------------------------------------------
    // Screen model: its own copy of the cells, cursor and attribute.
    // ------------------------------------------------------------------
    logic [VALUE_W-1:0] screen_model [CELLS];
    int                 cur_row = 0;
    int                 cur_col = 0;
    logic [ATTR_W-1:0]  attr_model = tcw_pkg::ATTR_RESET;

    console_req_t   outgoing_reqs [$];    // waiting for the driver
    console_reply_t awaited_replies [$];  // predicted, not yet seen on the output

    int unsigned error_count = 0;
    int unsigned reqs_taken = 0;
    int unsigned next_stall_at = 40;
    int unsigned stall_left = 0;
    bit          jitter_on = 1'b1;
    logic        req_fire = 1'b0;

    initial
    begin
        for (int i = 0; i < CELLS; i++)
            screen_model[CIW'(i)] = '0;
    end

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Cursor moves down a row; past the last row, shift everything up one
    // row and blank the bottom row, and the cursor stays on the last row.
    function automatic void step_down_row();
        cur_row++;
        if (cur_row >= ROWS)
        begin
            for (int i = 0; i < CELLS - COLS; i++)
                screen_model[CIW'(i)] = screen_model[CIW'(i + COLS)];
            for (int i = CELLS - COLS; i < CELLS; i++)
                screen_model[CIW'(i)] = '0;
            cur_row = ROWS - 1;
        end
    endfunction

    // Applies one request to the screen model and returns its response.
    function automatic console_reply_t apply_to_screen(logic kind, logic [CHAR_W-1:0] ch,
                                                       logic [INDEX_W-1:0] idx);
        console_reply_t reply;
        tcw_pkg::op_t   op;
        reply.cell_value = '0;
        if (kind == tcw_pkg::KIND_READ)
            op = tcw_pkg::OP_READ;
        else if (ch == tcw_pkg::CH_NEWLINE)
            op = tcw_pkg::OP_NEWLINE;
        else if (ch == tcw_pkg::CH_RETURN)
            op = tcw_pkg::OP_RETURN;
        else if (ch == tcw_pkg::CH_BACKSPACE)
            op = tcw_pkg::OP_BACKSPACE;
        else if (ch == tcw_pkg::CH_TAB)
            op = tcw_pkg::OP_TAB;
        else
            op = tcw_pkg::OP_GLYPH;

        case (op)
            tcw_pkg::OP_READ:
            begin
                // beyond the screen reads as zero
                if (int'(idx) < CELLS)
                    reply.cell_value = screen_model[idx];
            end
            tcw_pkg::OP_NEWLINE:
            begin
                cur_col = 0;
                step_down_row();
            end
            tcw_pkg::OP_RETURN:
                cur_col = 0;
            tcw_pkg::OP_BACKSPACE:
            begin
                // column 0 goes up a row, never above row 0
                if (cur_col > 0)
                    cur_col--;
                else if (cur_row > 0)
                    cur_row--;
            end
            tcw_pkg::OP_TAB:
            begin
                cur_col = (cur_col + tcw_pkg::TAB_STEP) & ~(tcw_pkg::TAB_STEP - 1);
                if (cur_col >= COLS)
                begin
                    cur_col = 0;
                    step_down_row();
                end
            end
            default:
            begin
                screen_model[CIW'(cur_row * COLS + cur_col)] = {attr_model, ch};
                cur_col++;
                if (cur_col >= COLS)
                begin
                    cur_col = 0;
                    step_down_row();
                end
            end
        endcase
        reply.cursor_row = cur_row[ROW_OUT_W-1:0];
        reply.cursor_col = cur_col[COL_OUT_W-1:0];
        return reply;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (error_count < 40)
            $display("mismatch %s: got 0x%0h, expected 0x%0h (t=%0t)", what, got, want, $time);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Request side: prediction at the accepting edge, driving at the
    // falling edge. A new request goes out only once the slot is free.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        req_fire <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            awaited_replies.push_back(apply_to_screen(s_tuser[0], s_tdata[7:0],
                                                      s_tdata[18:8]));
            reqs_taken <= reqs_taken + 1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || req_fire))
        begin
            if (outgoing_reqs.size() != 0 &&
                !(jitter_on && $urandom_range(99) < JITTER_PCT))
            begin
                console_req_t r;
                r = outgoing_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {5'b0, r.cell_index, r.char_code};
                s_tuser  <= r.kind;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Response side: random back-pressure, plus a long hold-off every
    // STALL_GAP requests so the internal queue fills and s_tready drops.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (rst_n && reqs_taken >= next_stall_at)
        begin
            stall_left    <= STALL_LEN;
            next_stall_at <= next_stall_at + STALL_GAP;
            m_tready      <= 1'b0;
        end
        else if (jitter_on)
        begin
            m_tready <= ($urandom_range(99) >= JITTER_PCT);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_replies.size() == 0)
            begin
                report_mismatch("response with no request pending", m_tdata, 0);
            end
            else
            begin
                console_reply_t want;
                want = awaited_replies.pop_front();
                if (m_tdata[15:0] !== want.cell_value)
                    report_mismatch("cell_value", 32'(m_tdata[15:0]), 32'(want.cell_value));
                if (m_tdata[20:16] !== want.cursor_row)
                    report_mismatch("cursor_row", 32'(m_tdata[20:16]), 32'(want.cursor_row));
                if (m_tdata[27:21] !== want.cursor_col)
                    report_mismatch("cursor_col", 32'(m_tdata[27:21]), 32'(want.cursor_col));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_put(input logic [CHAR_W-1:0] ch);
        console_req_t r;
        r.kind       = tcw_pkg::KIND_PUT;
        r.char_code  = ch;
        r.cell_index = INDEX_W'($urandom_range(0, 2047));   // ignored for puts, toggled anyway
        outgoing_reqs.push_back(r);
    endtask

    task automatic push_read(input logic [INDEX_W-1:0] idx);
        console_req_t r;
        r.kind       = tcw_pkg::KIND_READ;
        r.char_code  = CHAR_W'($urandom_range(0, 255));
        r.cell_index = idx;
        outgoing_reqs.push_back(r);
    endtask

    // Reads lean toward the bottom row, where recent text lands.
    task automatic push_random_read();
        if ($urandom_range(1) == 0)
            push_read(INDEX_W'($urandom_range(CELLS - COLS, CELLS - 1)));
        else
            push_read(INDEX_W'($urandom_range(0, 2047)));
    endtask

    // Mostly lines of bytes other than the four control characters, with reads
    // mixed in, each closed by a control character; the rest is arbitrary noise requests.
    task automatic queue_random_text(input int count);
        int                made;
        int                line_len;
        logic [CHAR_W-1:0] c;
        console_req_t      r;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(9) < 7)
            begin
                if ($urandom_range(9) == 0)
                    line_len = $urandom_range(60, 90);   // can be long enough to wrap
                else
                    line_len = $urandom_range(0, 16);
                repeat (line_len)
                begin
                    if ($urandom_range(3) == 0)
                    begin
                        push_random_read();
                    end
                    else
                    begin
                        do
                            c = CHAR_W'($urandom_range(0, 255));
                        while (c == tcw_pkg::CH_NEWLINE || c == tcw_pkg::CH_RETURN ||
                               c == tcw_pkg::CH_BACKSPACE || c == tcw_pkg::CH_TAB);
                        push_put(c);
                    end
                    made++;
                end
                case ($urandom_range(5))
                    0, 1, 2: push_put(tcw_pkg::CH_NEWLINE);
                    3:       push_put(tcw_pkg::CH_RETURN);
                    4:       push_put(tcw_pkg::CH_TAB);
                    default: push_put(tcw_pkg::CH_BACKSPACE);
                endcase
                made++;
            end
            else
            begin
                r.kind       = 1'($urandom_range(0, 1));
                r.char_code  = CHAR_W'($urandom_range(0, 255));
                r.cell_index = INDEX_W'($urandom_range(0, 2047));
                outgoing_reqs.push_back(r);
                made++;
            end
        end
    endtask

    // Block is idle once nothing is queued, offered or awaited.
    task automatic wait_for_drain();
        while (outgoing_reqs.size() != 0 || s_tvalid || awaited_replies.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en  <= 1'b0;
        attr_model = value;
    endtask

    initial
    begin
        logic [ATTR_W-1:0] attr;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: runs with the reset attribute. Covers backspace pinned at
        // the home position, glyph byte extremes, return, tab, newline,
        // backspace up a row, reads past the screen end, and a tab run that
        // wraps to the next row.
        push_put(tcw_pkg::CH_BACKSPACE);
        push_read(11'd0);
        push_put(8'h00);
        push_put(8'hFF);
        push_put(tcw_pkg::CH_BACKSPACE);
        push_put(tcw_pkg::CH_RETURN);
        push_read(11'd1);
        push_put(tcw_pkg::CH_TAB);
        push_put(8'h41);
        push_put(tcw_pkg::CH_NEWLINE);
        push_put(tcw_pkg::CH_BACKSPACE);
        push_read(11'd2047);
        push_read(11'd2000);
        push_read(11'd1999);
        repeat (10) push_put(tcw_pkg::CH_TAB);   // last one wraps from column 72
        push_read(11'd8);
        wait_for_drain();

        // Random phases, each under its own attribute; one phase runs with
        // no random idling on either side.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:       attr = 8'h00;
                1:       attr = 8'hFF;
                2:       attr = ATTR_W'($urandom_range(1, 254));
                3:       attr = 8'h80;
                default: attr = ATTR_W'($urandom_range(0, 255));
            endcase
            write_attribute(attr);
            jitter_on = (ph != 2);
            queue_random_text(345);
            wait_for_drain();
        end

        // room for a stray late response (one full scroll)
        repeat (CELLS + 100) @(negedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #(2 * CLK_HALF * 3000000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
